// File: hdl/assert_macros.svh
// Assertion helpers, sampled on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define WIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define WIS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/wis_pkg.sv
package wis_pkg;

  localparam int MAX_PARTICLES = 512;
  localparam int WEIGHT_BITS   = 32;

  localparam int IDX_W    = $clog2(MAX_PARTICLES);
  localparam int CNT_W    = $clog2(MAX_PARTICLES + 1);
  localparam int CFG_W    = 10;
  localparam int WEIGHT_W = 32;
  localparam int FRAC_W   = 32;
  localparam int TOTAL_W  = 41;
  localparam int HI_W     = TOTAL_W - FRAC_W;
  localparam int PICK_W   = 9;
  localparam int STATUS_W = 2;

  localparam logic [TOTAL_W-1:0]  TOTAL_MAX   = '1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MASK =
    WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);
  localparam logic [CFG_W-1:0]    CFG_RESET   = CFG_W'(512);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_DROP       = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_TOT,
    S_MUL,
    S_SRCH,
    S_DONE
  } state_e;

endpackage

// File: hdl/wis_req_if.sv
interface wis_req_if import wis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic                start_req;
  logic [WEIGHT_W-1:0] weight;
  logic [FRAC_W-1:0]   fraction;

  modport source (output valid, opcode, start_req, weight, fraction, input ready);
  modport sink   (input valid, opcode, start_req, weight, fraction, output ready);
endinterface

// File: hdl/wis_rsp_if.sv
interface wis_rsp_if import wis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PICK_W-1:0]   picked_index;
  logic [TOTAL_W-1:0]  running_total;
  logic [STATUS_W-1:0] status;

  modport source (output valid, picked_index, running_total, status, input ready);
  modport sink   (input valid, picked_index, running_total, status, output ready);
endinterface

// File: hdl/wis_ram.sv
module wis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hdl/weighted_index_sampler_unit.sv
// Weighted index sampler for multinomial particle resampling.
// req_i carries one request per valid/ready handshake: a load (opcode 0)
// appends a weight to the prefix-sum table, start_req restarting it at entry
// zero; a sample (opcode 1) scales fraction by the table total and binary
// searches the prefix sums for the matching index. rsp_o returns exactly one
// response per request: picked_index, running_total and status.
// cfg_we_i/cfg_wdata_i write particle_count; the user must do so only while no
// request is in flight, as the unit itself does not enforce this. A load or an
// incomplete-table sample goes from S_DEC to S_DONE; other samples read the
// total in S_TOT, end there on a zero total, else scale the fraction by it
// into a target and, unless there is one entry, binary search in S_SRCH, one
// prefix-sum memory read per search step. One request is worked on at a time;
// the next is taken the cycle after the response enters the output register.
// A stalled response holds in the output register; the unit then waits in
// its final state and takes no new request until that slot frees.
// Reset clears the count, the total and the control state and sets
// particle_count to 512; the prefix-sum memory is not cleared, loads
// write each entry before any sample may read it.
module weighted_index_sampler_unit
  import wis_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  wis_req_if.sink          req_i,
  wis_rsp_if.source        rsp_o
);

  `include "assert_macros.svh"

  localparam int CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  state_e              state_q, state_d;
  logic [CFG_W-1:0]    count_cfg_q;
  logic                op_q;
  logic                start_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [FRAC_W-1:0]   frac_q;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]    loaded_q, loaded_d;
  logic [TOTAL_W-1:0]  p_hi_q, p_hi_d;
  logic [FRAC_W-1:0]   p_lo_q, p_lo_d;
  logic [TOTAL_W-1:0]  target_q, target_d;
  logic [CNT_W-1:0]    low_q, low_d, high_q, high_d;
  logic [CNT_W-1:0]    res_idx_q, res_idx_d;
  status_e             res_status_q, res_status_d;
  logic                out_valid_q, out_valid_d;
  logic [PICK_W-1:0]   out_idx_q;
  logic [TOTAL_W-1:0]  out_total_q;
  status_e             out_status_q;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [TOTAL_W-1:0]  ram_wdata, ram_rdata;

  logic [CMP_W-1:0]    cfg_ext;
  logic [CNT_W-1:0]    n_eff;
  logic                req_fire, out_free, load_drop, incomplete;
  logic [CNT_W-1:0]    base_cnt;
  logic [TOTAL_W-1:0]  base_tot;
  logic [TOTAL_W:0]    sum_ext;
  logic [CNT_W-1:0]    mid_cur, mid_next, step_low, step_high;
  logic                step_go;
  logic [2*FRAC_W-1:0] prod_lo;
  logic [TOTAL_W-1:0]  prod_hi;

  function automatic logic [CNT_W-1:0] mid_of(logic [CNT_W-1:0] lo, logic [CNT_W-1:0] hi);
    logic [CNT_W:0] s;
    s = {1'b0, lo} + {1'b0, hi};
    return s[CNT_W:1];
  endfunction

  wis_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (MAX_PARTICLES)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // effective particle count, clamped to [1, MAX_PARTICLES]
  always_comb begin
    cfg_ext = CMP_W'(count_cfg_q);
    if (cfg_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_PARTICLES)) begin
      n_eff = CNT_W'(MAX_PARTICLES);
    end else begin
      n_eff = CNT_W'(cfg_ext);
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign base_cnt   = start_q ? '0 : loaded_q;
  assign base_tot   = start_q ? '0 : total_q;
  assign load_drop  = (base_cnt >= n_eff);
  assign sum_ext    = {1'b0, base_tot} + (TOTAL_W + 1)'(weight_q & WEIGHT_MASK);
  assign incomplete = (loaded_q < n_eff);

  assign prod_lo = (2 * FRAC_W)'(frac_q) * (2 * FRAC_W)'(ram_rdata[FRAC_W-1:0]);
  assign prod_hi = TOTAL_W'(frac_q) * TOTAL_W'(ram_rdata[TOTAL_W-1:FRAC_W]);

  // one search step: compare against prefix_sums[mid - 1]
  always_comb begin
    mid_cur   = mid_of(low_q, high_q);
    step_low  = low_q;
    step_high = high_q;
    if (target_q < ram_rdata) begin
      step_high = mid_cur;
    end else begin
      step_low = mid_cur;
    end
    step_go  = (CNT_W + 1)'(step_low) + (CNT_W + 1)'(1) < (CNT_W + 1)'(step_high);
    mid_next = mid_of(step_low, step_high);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (op_q == OP_LOAD || incomplete) begin
          state_d = S_DONE;
        end else begin
          state_d = S_TOT;
        end
      end
      S_TOT: begin
        state_d = (ram_rdata == '0) ? S_DONE : S_MUL;
      end
      S_MUL: begin
        state_d = (n_eff == CNT_W'(1)) ? S_DONE : S_SRCH;
      end
      S_SRCH: begin
        if (!step_go) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    total_d      = total_q;
    loaded_d     = loaded_q;
    p_hi_d       = p_hi_q;
    p_lo_d       = p_lo_q;
    target_d     = target_q;
    low_d        = low_q;
    high_d       = high_q;
    res_idx_d    = res_idx_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = base_cnt[IDX_W-1:0];
    ram_wdata    = (sum_ext > (TOTAL_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
    ram_raddr    = mid_next - CNT_W'(1) < CNT_W'(MAX_PARTICLES) ?
                   IDX_W'(mid_next - CNT_W'(1)) : '0;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    unique case (state_q)
      S_DEC: begin
        res_idx_d    = '0;
        res_status_d = ST_OK;
        ram_raddr    = IDX_W'(n_eff - CNT_W'(1));
        if (op_q == OP_LOAD) begin
          total_d  = base_tot;
          loaded_d = base_cnt;
          if (load_drop) begin
            res_status_d = ST_DROP;
          end else begin
            ram_we   = 1'b1;
            total_d  = ram_wdata;
            loaded_d = base_cnt + CNT_W'(1);
          end
        end else if (incomplete) begin
          res_status_d = ST_INCOMPLETE;
        end
      end
      S_TOT: begin
        res_idx_d = n_eff - CNT_W'(1);
        p_hi_d    = prod_hi;
        p_lo_d    = prod_lo[2*FRAC_W-1:FRAC_W];
      end
      S_MUL: begin
        target_d  = p_hi_q + TOTAL_W'(p_lo_q);
        low_d     = '0;
        high_d    = n_eff;
        res_idx_d = '0;
        ram_raddr = IDX_W'(mid_of('0, n_eff) - CNT_W'(1));
      end
      S_SRCH: begin
        low_d     = step_low;
        high_d    = step_high;
        res_idx_d = step_low;
        ram_raddr = IDX_W'(mid_next - CNT_W'(1));
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_cfg_q  <= CFG_RESET;
      total_q      <= '0;
      loaded_q     <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      total_q      <= total_d;
      loaded_q     <= loaded_d;
      out_valid_q  <= out_valid_d;
      res_status_q <= res_status_d;
      if (cfg_we_i) begin
        count_cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q     <= req_i.opcode;
      start_q  <= req_i.start_req;
      weight_q <= req_i.weight;
      frac_q   <= req_i.fraction;
    end
    p_hi_q    <= p_hi_d;
    p_lo_q    <= p_lo_d;
    target_q  <= target_d;
    low_q     <= low_d;
    high_q    <= high_d;
    res_idx_q <= res_idx_d;
    if (state_q == S_DONE && out_free) begin
      out_idx_q    <= PICK_W'(res_idx_q);
      out_total_q  <= total_q;
      out_status_q <= res_status_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.picked_index  = out_idx_q;
  assign rsp_o.running_total = out_total_q;
  assign rsp_o.status        = out_status_q;

  `WIS_ASSERT(a_fire_dec, req_fire |=> state_q == S_DEC, "accepted request not decoded")
  `WIS_ASSERT(a_cnt_max, loaded_q <= CNT_W'(MAX_PARTICLES), "loaded count beyond table depth")
  `WIS_ASSERT(a_srch_order, state_q == S_SRCH |-> low_q < high_q, "search bounds crossed")
  `WIS_ASSERT(a_incomplete_zero,
              rsp_o.valid && rsp_o.status == ST_INCOMPLETE |-> rsp_o.picked_index == '0,
              "incomplete-table response with nonzero index")
  `WIS_ASSERT_RST(a_rst_quiet, !rst_ni |-> !rsp_o.valid, "response valid during reset")

endmodule

// File: test/tb_weighted_index_sampler_unit.sv
module tb_weighted_index_sampler_unit;
  import wis_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_GOAL   = 1350;
  localparam int PROD_W      = FRAC_W + TOTAL_W;

  typedef struct {
    logic [PICK_W-1:0]  pick;
    logic [TOTAL_W-1:0] sum;
    status_e            status;
  } pick_t;

  class sampler_board;
    logic [TOTAL_W-1:0] sums [MAX_PARTICLES];
    logic [TOTAL_W-1:0] total;
    int unsigned        loaded;
    logic [CFG_W-1:0]   count_reg;
    pick_t              pending_picks[$];
    int                 failures;
    int                 n_picks;
    int                 n_drops;
    int                 n_incomplete;
    int                 n_zero;

    function new();
      total     = '0;
      loaded    = 0;
      count_reg = CFG_RESET;
      foreach (sums[i]) sums[i] = '0;
    endfunction

    function int unsigned span();
      int unsigned n;
      n = count_reg;
      if (n < 1) n = 1;
      if (n > MAX_PARTICLES) n = MAX_PARTICLES;
      return n;
    endfunction

    function void record_request(opcode_e op, logic start, logic [WEIGHT_W-1:0] w,
                                 logic [FRAC_W-1:0] f);
      int unsigned         n, lo, hi, mid;
      logic [TOTAL_W:0]    s;
      logic [TOTAL_W-1:0]  top, target;
      logic [PROD_W-1:0]   prod;
      pick_t               e;
      n        = span();
      e.pick   = '0;
      e.status = ST_OK;
      if (op == OP_LOAD) begin
        if (start) begin
          loaded = 0;
          total  = '0;
        end
        if (loaded >= n) begin
          e.status = ST_DROP;
          n_drops++;
        end else begin
          s = {1'b0, total} + (w & WEIGHT_MASK);
          if (s > {1'b0, TOTAL_MAX}) s = {1'b0, TOTAL_MAX};
          total        = s[TOTAL_W-1:0];
          sums[loaded] = total;
          loaded++;
        end
      end else if (loaded < n) begin
        e.status = ST_INCOMPLETE;
        n_incomplete++;
      end else begin
        top = sums[n-1];
        if (top == '0) begin
          e.pick = PICK_W'(n - 1);
          n_zero++;
        end else begin
          prod   = PROD_W'(f) * PROD_W'(top);
          target = prod[PROD_W-1:FRAC_W];
          lo = 0;
          hi = n;
          while (lo + 1 < hi) begin
            mid = (lo + hi) / 2;
            if (target < sums[mid-1]) hi = mid;
            else lo = mid;
          end
          e.pick = PICK_W'(lo);
          n_picks++;
        end
      end
      e.sum = total;
      pending_picks.push_back(e);
    endfunction

    function void check_pick(logic [PICK_W-1:0] pick, logic [TOTAL_W-1:0] sum,
                             logic [STATUS_W-1:0] status);
      pick_t e;
      if (pending_picks.size() == 0) begin
        $error("response with no request pending");
        failures++;
        return;
      end
      e = pending_picks.pop_front();
      if (pick !== e.pick) begin
        $error("picked_index: expected %0d, got %0d", e.pick, pick);
        failures++;
      end
      if (sum !== e.sum) begin
        $error("running_total: expected %0d, got %0d", e.sum, sum);
        failures++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        failures++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  wis_req_if req_bus();
  wis_rsp_if rsp_bus();

  sampler_board sb = new();

  int sent;
  int phases;
  int cycles;
  int stall_left;
  bit no_idle;
  bit rsp_steady;

  weighted_index_sampler_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("weighted_index_sampler_unit: mismatch");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // response backpressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!rsp_steady && $urandom_range(0, 99) < 25) begin
      rsp_bus.ready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready)
      sb.check_pick(rsp_bus.picked_index, rsp_bus.running_total, rsp_bus.status);
  end

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    if (r < 50) return WEIGHT_W'($urandom_range(0, 15));
    return $urandom;
  endfunction

  function automatic logic [FRAC_W-1:0] rand_fraction();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  task automatic send_request(input opcode_e op, input logic start,
                              input logic [WEIGHT_W-1:0] w, input logic [FRAC_W-1:0] f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      req_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_bus.valid     <= 1'b1;
    req_bus.opcode    <= op;
    req_bus.start_req <= start;
    req_bus.weight    <= w;
    req_bus.fraction  <= f;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    sb.record_request(op, start, w, f);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (sb.pending_picks.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    drain();
    cfg_we       <= 1'b1;
    cfg_wdata    <= value;
    sb.count_reg = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    send_request(OP_SAMPLE, 1'b1, '1, '0);
    write_count(CFG_W'(3));
    send_request(OP_LOAD, 1'b1, '0, '0);
    send_request(OP_LOAD, 1'b0, '0, '1);
    send_request(OP_SAMPLE, 1'b0, '0, '1);
    send_request(OP_LOAD, 1'b0, '0, '0);
    send_request(OP_SAMPLE, 1'b0, '0, '1);
    send_request(OP_LOAD, 1'b0, WEIGHT_W'(5), '0);
    send_request(OP_LOAD, 1'b1, '1, '0);
    send_request(OP_LOAD, 1'b0, '0, '0);
    send_request(OP_LOAD, 1'b0, '1, '0);
    send_request(OP_SAMPLE, 1'b0, '0, '0);
    send_request(OP_SAMPLE, 1'b0, '0, '1);
    send_request(OP_SAMPLE, 1'b0, '0, 32'h8000_0000);
    send_request(OP_SAMPLE, 1'b1, '1, 32'h7fff_ffff);
    // count lowered under a full table
    write_count(CFG_W'(2));
    send_request(OP_SAMPLE, 1'b0, '0, '1);
    send_request(OP_SAMPLE, 1'b0, '0, '0);
    write_count(CFG_W'(0));
    send_request(OP_SAMPLE, 1'b0, '0, 32'h1234_5678);
    send_request(OP_LOAD, 1'b0, '1, '0);
    // count raised past the table
    write_count(CFG_W'(5));
    send_request(OP_SAMPLE, 1'b0, '0, '1);
    send_request(OP_LOAD, 1'b0, WEIGHT_W'(1), '0);
    send_request(OP_LOAD, 1'b0, WEIGHT_W'(2), '0);
    send_request(OP_SAMPLE, 1'b0, '0, '1);
    send_request(OP_SAMPLE, 1'b0, '0, $urandom);
  endtask

  task automatic run_full_table();
    no_idle    = 1'b0;
    rsp_steady = 1'b0;
    write_count('1);
    for (int i = 0; i < MAX_PARTICLES; i++)
      send_request(OP_LOAD, i == 0, (i < 400) ? '1 : rand_weight(), $urandom);
    for (int i = 0; i < 3; i++)
      send_request(OP_LOAD, 1'b0, $urandom, $urandom);
    for (int i = 0; i < 30; i++)
      send_request(OP_SAMPLE, $urandom_range(0, 1), $urandom, rand_fraction());
    write_count(CFG_W'(MAX_PARTICLES));
    for (int i = 0; i < 10; i++)
      send_request(OP_SAMPLE, 1'b0, $urandom, rand_fraction());
    write_count(CFG_W'(256));
    for (int i = 0; i < 8; i++)
      send_request(OP_SAMPLE, 1'b0, $urandom, rand_fraction());
    phases++;
  endtask

  task automatic run_random_phase();
    int r, c, n, loads, draws;
    no_idle    = ($urandom_range(0, 4) == 0);
    rsp_steady = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 10) c = 0;
    else if (r < 20) c = 1;
    else if (r < 30) c = 2;
    else if (r < 80) c = $urandom_range(3, 16);
    else c = $urandom_range(17, 64);
    write_count(CFG_W'(c));
    n = (c < 1) ? 1 : c;
    // occasionally keep the old table to sample it under the new count
    if ($urandom_range(0, 9) != 0) begin
      r = $urandom_range(0, 9);
      loads = (r == 0) ? n - 1 : (r == 1) ? n + $urandom_range(1, 3) : n;
      for (int i = 0; i < loads; i++)
        send_request(OP_LOAD, i == 0, rand_weight(), $urandom);
    end
    draws = $urandom_range(4, 20);
    for (int i = 0; i < draws; i++) begin
      if ($urandom_range(0, 99) < 15)
        send_request(opcode_e'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                     rand_weight(), $urandom);
      else
        send_request(OP_SAMPLE, $urandom_range(0, 1), $urandom, rand_fraction());
    end
    phases++;
  endtask

  initial begin
    rst_ni            = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_bus.valid     = 1'b0;
    req_bus.opcode    = OP_LOAD;
    req_bus.start_req = 1'b0;
    req_bus.weight    = '0;
    req_bus.fraction  = '0;
    rsp_bus.ready     = 1'b0;
    #1 rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    run_full_table();
    while (sent < ITEM_GOAL) run_random_phase();

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.pending_picks.size() != 0) begin
      $error("%0d responses never arrived", sb.pending_picks.size());
      sb.failures++;
    end

    $display("covered %0d requests over %0d count settings in %0d cycles",
             sent, phases, cycles);
    $display("searched draws %0d, zero-total draws %0d, dropped loads %0d, incomplete draws %0d",
             sb.n_picks, sb.n_zero, sb.n_drops, sb.n_incomplete);
    if (sb.failures == 0) begin
      $display("weighted_index_sampler_unit: match");
    end else begin
      $display("weighted_index_sampler_unit: mismatch");
    end
    $finish;
  end

endmodule
